[design/ssa_pkg.sv]
// Shared types and constants for the shadow slot allocator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ssa_pkg;
   localparam int SLOTS_DEF = 8;
   localparam int MAX_CAND_DEF = 256;
   localparam logic [15:0] RET_ONE = 16'd256;
   localparam logic [15:0] HIDDEN_MAX = 16'hFFFF;
   localparam logic [15:0] GRACE_RESET = 16'd8;
   localparam logic [3:0] ACTIVE_RESET = 4'd8;
   localparam logic [1:0] REG_RETENTION = 2'd0;
   localparam logic [1:0] REG_GRACE = 2'd1;
   localparam logic [1:0] REG_ACTIVE = 2'd2;

   typedef struct packed {
      logic [63:0] light_key;
      logic        is_visible;
      logic [31:0] importance;
      logic        frame_end;
   } req_type;

   typedef struct packed {
      logic [7:0] candidate_index;
      logic [2:0] slot_index;
      logic       assigned;
      logic [3:0] displaced_count;
      logic       last_result;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic rank;    // match and insert the latched candidate
      logic clean;   // clear unmatched and evicted slots
      logic emit;    // assign and emit the entry at the emit pointer
      logic finish;  // reset per-frame state
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_end;
      logic last_emit;
   } sts_type;
endpackage
`default_nettype wire

[design/shadow_slot_allocator_unit.sv]
// Top level of the shadow slot allocator: CSR port, controller, datapath.
// Depends on ssa_pkg, ssa_control and ssa_datapath.
//
// Usage: drive req_data with start while busy is low; the item transfers
// at that edge. Each candidate is latched, then matched and inserted into
// the top list. A frame_end item then goes on through clean, emit (one
// result per cycle) and finish, giving N results (N at least 1). The first
// result follows the RANK, CLEAN and first EMIT states, the others follow
// on consecutive cycles. Results appear on rsp_data for one cycle with
// rsp_valid high; the receiver cannot stall. Registers sit at byte addresses
// 0, 4, 8 (retention, grace, active slots); the user must write them only
// while busy is low, as the block itself does not enforce it.
// Reset empties all slots and the top list, and restores register defaults.
`timescale 1ns / 1ps
`default_nettype none
module shadow_slot_allocator_unit import ssa_pkg::*; #(
   parameter int SLOTS = SLOTS_DEF,
   parameter int MAX_CANDIDATES = MAX_CAND_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   output rsp_type          rsp_data,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   logic [15:0] ret_ff, grace_ff;
   logic [3:0] act_ff;
   logic load;
   cmd_type cmd;
   sts_type sts;
   logic wr;

   assign csr_pready = 1'b1;
   assign wr = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         ret_ff <= RET_ONE;
         grace_ff <= GRACE_RESET;
         act_ff <= ACTIVE_RESET;
      end else if (wr && csr_paddr[1:0] == 2'd0) begin
         case (csr_paddr[3:2])
            REG_RETENTION: ret_ff <= (csr_pwdata[15:0] < RET_ONE) ? RET_ONE : csr_pwdata[15:0];
            REG_GRACE: grace_ff <= csr_pwdata[15:0];
            REG_ACTIVE: act_ff <= csr_pwdata[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_RETENTION: csr_prdata = {16'd0, ret_ff};
         REG_GRACE: csr_prdata = {16'd0, grace_ff};
         REG_ACTIVE: csr_prdata = {28'd0, act_ff};
         default: csr_prdata = '0;
      endcase
   end

   ssa_control u_ctl (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .load(load),
      .cmd(cmd), .sts(sts), .rsp_valid(rsp_valid)
   );

   ssa_datapath #(.SLOTS(SLOTS), .MAX_CANDIDATES(MAX_CANDIDATES)) u_dp (
      .clock(clock), .reset(reset), .load(load), .req_data(req_data), .cmd(cmd),
      .sts(sts), .retention(ret_ff), .grace(grace_ff), .active(act_ff),
      .rsp_data(rsp_data)
   );

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.rank, cmd.clean, cmd.emit, cmd.finish}))
      else $error("controller issued overlapping commands");
   a_no_load_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobe while idle");
   a_ret_floor: assert property (@(posedge clock) disable iff (reset)
      ret_ff >= RET_ONE)
      else $error("retention below one");
endmodule
`default_nettype wire

[design/ssa_datapath.sv]
// Slot table, top list and result formation of the shadow slot allocator.
// Depends on ssa_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ssa_datapath import ssa_pkg::*; #(
   parameter int SLOTS = SLOTS_DEF,
   parameter int MAX_CANDIDATES = MAX_CAND_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        load,
   input  wire req_type     req_data,
   input  wire cmd_type     cmd,
   output sts_type          sts,
   input  wire logic [15:0] retention,
   input  wire logic [15:0] grace,
   input  wire logic [3:0]  active,
   output rsp_type          rsp_data
);
   localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = $clog2(MAX_CANDIDATES + 1);
   localparam int NW = $clog2(SLOTS + 1);

   logic [63:0] key_ff [SLOTS];
   logic [15:0] hid_ff [SLOTS];
   logic [SLOTS-1:0] matched_ff;
   logic [7:0]  t_idx_ff [SLOTS];
   logic [48:0] t_score_ff [SLOTS];
   logic [SW-1:0] t_os_ff [SLOTS];
   logic [SLOTS-1:0] t_has_ff;
   logic [63:0] t_key_ff [SLOTS];
   logic [NW-1:0] t_cnt_ff;
   logic [CW-1:0] arr_ff;
   logic [3:0]  disp_ff;
   logic [NW-1:0] ptr_ff;
   req_type     cand_ff;
   logic        ok_ff;
   logic [7:0]  cidx_ff;
   rsp_type     rsp_ff;

   logic [NW-1:0] sc, n;
   assign sc = (NW'(active) > NW'(SLOTS)) ? NW'(SLOTS) : NW'(active);
   assign n = (t_cnt_ff < sc) ? t_cnt_ff : sc;

   // match
   logic [SLOTS-1:0] hit;
   logic owned;
   logic [SW-1:0] os;
   logic [15:0] os_hid;
   always_comb begin
      owned = 1'b0;
      os = '0;
      for (int s = 0; s < SLOTS; s++) begin
         hit[s] = (NW'(s) < sc) && key_ff[s] == cand_ff.light_key && !matched_ff[s];
         if (hit[s]) begin
            owned = 1'b1;
            os = SW'(s);
         end
      end
      if (cand_ff.is_visible) os_hid = '0;
      else if (hid_ff[os] < HIDDEN_MAX) os_hid = hid_ff[os] + 16'd1;
      else os_hid = hid_ff[os];
   end
   logic seen;
   logic [47:0] score;
   logic [48:0] rank;
   assign seen = cand_ff.is_visible || (owned && os_hid <= grace);
   assign score = {16'd0, cand_ff.importance} * (owned ? {32'd0, retention} : {32'd0, RET_ONE});
   assign rank = {seen, score};

   // insertion position: count of kept entries with score >= rank
   logic [SLOTS-1:0] ge;
   logic [NW-1:0] pos, wc;
   always_comb begin
      pos = '0;
      for (int i = 0; i < SLOTS; i++) begin
         ge[i] = (NW'(i) < n) && !(rank > t_score_ff[i]);
         if (ge[i]) pos = NW'(i + 1);
      end
      wc = (n + NW'(1) > sc) ? sc : n + NW'(1);
   end

   // retention and cleaning
   logic [SLOTS-1:0] retained;
   always_comb begin
      retained = '0;
      for (int w = 0; w < SLOTS; w++)
         if (NW'(w) < n && t_has_ff[w] && NW'(t_os_ff[w]) < sc) retained[t_os_ff[w]] = 1'b1;
   end
   logic [SLOTS-1:0] evict;
   logic [3:0] evict_cnt;
   always_comb begin
      evict_cnt = '0;
      for (int s = 0; s < SLOTS; s++) begin
         evict[s] = (NW'(s) < sc) && key_ff[s] != 64'd0 && matched_ff[s] && !retained[s];
         evict_cnt = evict_cnt + 4'(evict[s]);
      end
   end

   // emission of one entry
   logic [SW-1:0] ep, fslot;
   logic ffound, e_keep, e_any;
   assign ep = ptr_ff[SW-1:0];
   assign e_any = (n != '0);
   assign e_keep = t_has_ff[ep] && NW'(t_os_ff[ep]) < sc;
   always_comb begin
      ffound = 1'b0;
      fslot = '0;
      for (int s = SLOTS - 1; s >= 0; s--)
         if (NW'(s) < sc && key_ff[s] == 64'd0) begin
            ffound = 1'b1;
            fslot = SW'(s);
         end
   end

   assign sts.is_end = cand_ff.frame_end;
   assign sts.last_emit = !e_any || (ptr_ff + NW'(1) >= n);
   assign rsp_data = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < SLOTS; s++) begin
            key_ff[s] <= '0;
            hid_ff[s] <= '0;
         end
         matched_ff <= '0;
         t_cnt_ff <= '0;
         arr_ff <= '0;
      end else begin
         if (load) begin
            cand_ff <= req_data;
            ok_ff <= arr_ff < CW'(MAX_CANDIDATES);
            cidx_ff <= 8'(arr_ff);
            if (arr_ff < CW'(MAX_CANDIDATES)) arr_ff <= arr_ff + CW'(1);
         end
         if (cmd.rank && ok_ff && cand_ff.light_key != 64'd0) begin
            for (int s = 0; s < SLOTS; s++)
               if (hit[s]) begin
                  matched_ff[s] <= 1'b1;
                  if (cand_ff.is_visible) hid_ff[s] <= '0;
                  else if (hid_ff[s] < HIDDEN_MAX) hid_ff[s] <= hid_ff[s] + 16'd1;
               end
            if (pos < sc) begin
               for (int i = 1; i < SLOTS; i++)
                  if (NW'(i) > pos && NW'(i) < wc) begin
                     t_idx_ff[i] <= t_idx_ff[i-1];
                     t_score_ff[i] <= t_score_ff[i-1];
                     t_os_ff[i] <= t_os_ff[i-1];
                     t_has_ff[i] <= t_has_ff[i-1];
                     t_key_ff[i] <= t_key_ff[i-1];
                  end
               t_idx_ff[pos[SW-1:0]] <= cidx_ff;
               t_score_ff[pos[SW-1:0]] <= rank;
               t_os_ff[pos[SW-1:0]] <= os;
               t_has_ff[pos[SW-1:0]] <= owned;
               t_key_ff[pos[SW-1:0]] <= cand_ff.light_key;
               t_cnt_ff <= wc;
            end
         end
         if (cmd.clean) begin
            for (int s = 0; s < SLOTS; s++)
               if (NW'(s) < sc && (evict[s] || !matched_ff[s])) begin
                  key_ff[s] <= '0;
                  hid_ff[s] <= '0;
               end
            disp_ff <= evict_cnt;
            ptr_ff <= '0;
         end
         if (cmd.emit) begin
            rsp_ff.displaced_count <= disp_ff;
            rsp_ff.last_result <= sts.last_emit;
            if (!e_any) begin
               rsp_ff.candidate_index <= '0;
               rsp_ff.slot_index <= '0;
               rsp_ff.assigned <= 1'b0;
            end else begin
               rsp_ff.candidate_index <= t_idx_ff[ep];
               if (e_keep) begin
                  rsp_ff.slot_index <= 3'(t_os_ff[ep]);
                  rsp_ff.assigned <= 1'b1;
               end else if (ffound) begin
                  rsp_ff.slot_index <= 3'(fslot);
                  rsp_ff.assigned <= 1'b1;
                  key_ff[fslot] <= t_key_ff[ep];
                  hid_ff[fslot] <= '0;
               end else begin
                  rsp_ff.slot_index <= '0;
                  rsp_ff.assigned <= 1'b0;
               end
            end
            ptr_ff <= ptr_ff + NW'(1);
         end
         if (cmd.finish) begin
            matched_ff <= '0;
            t_cnt_ff <= '0;
            arr_ff <= '0;
         end
      end
   end
endmodule
`default_nettype wire

[design/ssa_control.sv]
// Sequencer of the shadow slot allocator: rank, clean, emit, finish.
// Depends on ssa_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ssa_control import ssa_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   output logic      busy,
   output logic      load,
   output cmd_type   cmd,
   input  wire sts_type sts,
   output logic      rsp_valid
);
   typedef enum logic [2:0] {IDLE, RANK, CLEAN, EMIT, DONE} state_type;
   state_type state_ff, state_in;
   logic valid_ff, valid_in;

   assign busy = (state_ff != IDLE);
   assign load = start && !busy;
   assign rsp_valid = valid_ff;

   always_comb begin
      state_in = state_ff;
      valid_in = 1'b0;
      cmd = '0;
      case (state_ff)
         IDLE: if (load) state_in = RANK;
         RANK: begin
            cmd.rank = 1'b1;
            state_in = sts.is_end ? CLEAN : IDLE;
         end
         CLEAN: begin
            cmd.clean = 1'b1;
            state_in = EMIT;
         end
         EMIT: begin
            cmd.emit = 1'b1;
            valid_in = 1'b1;
            if (sts.last_emit) state_in = DONE;
         end
         DONE: begin
            cmd.finish = 1'b1;
            state_in = IDLE;
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end
endmodule
`default_nettype wire

[tb/sv/ssa_checker.sv]
// Scoreboard for the shadow slot allocator: follows CSR writes and accepted
// candidates, predicts each frame's slot assignments and checks every result.
// Depends on ssa_pkg.
`timescale 1ns / 1ps
module ssa_checker import ssa_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  rsp_type     rsp_data,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic        csr_pready,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output int          fail_count,
   output int          pending
);
   localparam int NSLOT = 8;
   localparam int MAXC = 256;

   logic [15:0] retention;
   logic [15:0] grace;
   logic [3:0]  active;

   logic [63:0] slot_key[NSLOT];
   logic [15:0] slot_hidden[NSLOT];
   bit          slot_taken[NSLOT];
   logic [7:0]  rank_idx[NSLOT];
   logic [48:0] rank_val[NSLOT];
   int          rank_slot[NSLOT];
   bit          rank_owned[NSLOT];
   logic [63:0] rank_key[NSLOT];
   int          rank_count;
   int          arrivals;

   rsp_type expected_q[$];

   assign pending = expected_q.size();

   task automatic report(string field, int got, int exp);
      $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, field, got, exp);
      fail_count++;
   endtask

   function automatic int slot_limit();
      return active > NSLOT ? NSLOT : int'(active);
   endfunction

   task automatic rank_candidate(req_type it, int idx, int sc);
      bit owned;
      int os;
      bit seen;
      logic [47:0] score;
      logic [48:0] rv;
      int n, pos, wc;
      owned = 0;
      os = 0;
      for (int s = 0; s < sc; s++) begin
         if (slot_key[s] == it.light_key && !slot_taken[s]) begin
            slot_taken[s] = 1;
            if (it.is_visible) slot_hidden[s] = 0;
            else if (slot_hidden[s] != HIDDEN_MAX) slot_hidden[s]++;
            owned = 1;
            os = s;
         end
      end
      seen = it.is_visible || (owned && slot_hidden[os] <= grace);
      score = 48'(it.importance) * 48'(owned ? retention : RET_ONE);
      rv = {seen, score};
      n = rank_count < sc ? rank_count : sc;
      pos = n;
      while (pos > 0 && rv > rank_val[pos-1]) pos--;
      if (pos >= sc) return;
      wc = n + 1 > sc ? sc : n + 1;
      for (int i = wc - 1; i > pos; i--) begin
         rank_idx[i] = rank_idx[i-1];
         rank_val[i] = rank_val[i-1];
         rank_slot[i] = rank_slot[i-1];
         rank_owned[i] = rank_owned[i-1];
         rank_key[i] = rank_key[i-1];
      end
      rank_idx[pos] = 8'(idx);
      rank_val[pos] = rv;
      rank_slot[pos] = os;
      rank_owned[pos] = owned;
      rank_key[pos] = it.light_key;
      rank_count = wc;
   endtask

   task automatic close_frame(int sc);
      bit kept[NSLOT];
      int n, evicted, slot;
      bit asg;
      rsp_type r;
      rsp_type frame_q[$];
      n = rank_count < sc ? rank_count : sc;
      evicted = 0;
      for (int s = 0; s < NSLOT; s++) kept[s] = 0;
      for (int w = 0; w < n; w++)
         if (rank_owned[w] && rank_slot[w] < sc) kept[rank_slot[w]] = 1;
      for (int s = 0; s < sc; s++)
         if (slot_key[s] != 0 && !slot_taken[s]) begin
            slot_key[s] = 0;
            slot_hidden[s] = 0;
         end
      for (int s = 0; s < sc; s++)
         if (slot_key[s] != 0 && !kept[s]) begin
            slot_key[s] = 0;
            slot_hidden[s] = 0;
            evicted++;
         end
      for (int w = 0; w < n; w++) begin
         slot = 0;
         asg = 0;
         if (rank_owned[w] && rank_slot[w] < sc) begin
            slot = rank_slot[w];
            asg = 1;
         end else begin
            for (int s = 0; s < sc && !asg; s++)
               if (slot_key[s] == 0) begin
                  slot = s;
                  asg = 1;
               end
            if (asg) begin
               slot_key[slot] = rank_key[w];
               slot_hidden[slot] = 0;
            end else slot = 0;
         end
         r = '0;
         r.candidate_index = rank_idx[w];
         r.slot_index = 3'(slot);
         r.assigned = asg;
         frame_q.push_back(r);
      end
      if (frame_q.size() == 0) frame_q.push_back('0);
      foreach (frame_q[i]) begin
         frame_q[i].displaced_count = 4'(evicted);
         frame_q[i].last_result = (i == frame_q.size() - 1);
         expected_q.push_back(frame_q[i]);
      end
      for (int s = 0; s < NSLOT; s++) slot_taken[s] = 0;
      rank_count = 0;
      arrivals = 0;
   endtask

   task automatic predict_item(req_type it);
      int sc;
      sc = slot_limit();
      if (arrivals < MAXC) begin
         arrivals++;
         if (it.light_key != 0) rank_candidate(it, arrivals - 1, sc);
      end
      if (it.frame_end) close_frame(sc);
   endtask

   task automatic check_result(rsp_type got);
      rsp_type exp;
      if (expected_q.size() == 0) begin
         $display("%0t: result with nothing expected", $realtime);
         fail_count++;
         return;
      end
      exp = expected_q.pop_front();
      if (got.candidate_index !== exp.candidate_index)
         report("candidate_index", got.candidate_index, exp.candidate_index);
      if (got.slot_index !== exp.slot_index)
         report("slot_index", got.slot_index, exp.slot_index);
      if (got.assigned !== exp.assigned) report("assigned", got.assigned, exp.assigned);
      if (got.displaced_count !== exp.displaced_count)
         report("displaced_count", got.displaced_count, exp.displaced_count);
      if (got.last_result !== exp.last_result)
         report("last_result", got.last_result, exp.last_result);
   endtask

   initial fail_count = 0;

   always @(posedge clock) begin
      if (reset) begin
         retention <= RET_ONE;
         grace <= GRACE_RESET;
         active <= ACTIVE_RESET;
         for (int s = 0; s < NSLOT; s++) begin
            slot_key[s] = 0;
            slot_hidden[s] = 0;
            slot_taken[s] = 0;
         end
         rank_count = 0;
         arrivals = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[3:2])
               REG_RETENTION: begin
                  retention <= csr_pwdata[15:0] < RET_ONE ? RET_ONE : csr_pwdata[15:0];
               end
               REG_GRACE: grace <= csr_pwdata[15:0];
               REG_ACTIVE: active <= csr_pwdata[3:0];
               default: ;
            endcase
         end
         if (start && !busy) predict_item(req_data);
         if (rsp_valid) check_result(rsp_data);
      end
   end
endmodule

[tb/sv/shadow_slot_allocator_unit_tb.sv]
// Testbench top for shadow_slot_allocator_unit: clock, reset, candidate
// frames and CSR writes; checking lives in ssa_checker. Depends on ssa_pkg.
`timescale 1ns / 1ps
module shadow_slot_allocator_unit_tb;
   import ssa_pkg::*;

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   req_type     req_data = '0;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic        csr_psel = 0;
   logic        csr_penable = 0;
   logic        csr_pwrite = 0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   int          fail_count;
   int          pending;
   logic [63:0] key_pool[10];

   always #5 clock = ~clock;

   shadow_slot_allocator_unit dut (.*);

   ssa_checker checker_i (.*);

   // Hold until the block is idle with no result outstanding, then let it settle.
   task automatic wait_idle();
      start <= 0;
      do @(negedge clock); while (pending != 0 || busy);
      repeat (10) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [31:0] value);
      wait_idle();
      csr_psel <= 1;
      csr_penable <= 0;
      csr_pwrite <= 1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
      @(posedge clock);
   endtask

   task automatic send_item(logic [63:0] key, bit vis, logic [31:0] imp, bit last, int gap);
      req_type it;
      it.light_key = key;
      it.is_visible = vis;
      it.importance = imp;
      it.frame_end = last;
      if (gap > 0) begin
         start <= 0;
         repeat (gap) @(posedge clock);
      end
      start <= 1;
      req_data <= it;
      do @(negedge clock); while (busy);
      @(posedge clock);
   endtask

   function automatic logic [63:0] pick_key();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return 64'd0;
      if (r < 3) return {$urandom, $urandom};
      return key_pool[$urandom_range(0, 9)];
   endfunction

   function automatic logic [31:0] pick_imp();
      case ($urandom_range(0, 5))
         0: return 32'd0;
         1: return 32'hFFFF_FFFF;
         2: return $urandom_range(0, 255);
         default: return $urandom;
      endcase
   endfunction

   task automatic random_frame(int len);
      for (int i = 0; i < len; i++)
         send_item(pick_key(), $urandom_range(0, 1), pick_imp(), i == len - 1,
                   $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 5));
   endtask

   initial begin
      int items;
      logic [15:0] ret_set[6];
      logic [15:0] grace_set[6];
      logic [3:0] act_set[6];
      ret_set = '{16'd256, 16'hFFFF, 16'd0, 16'd300, 16'd255, 16'd512};
      grace_set = '{16'd0, 16'hFFFF, 16'd8, 16'd1, 16'd2, 16'd0};
      act_set = '{4'd8, 4'd1, 4'd0, 4'd12, 4'd3, 4'd15};
      for (int i = 0; i < 10; i++) key_pool[i] = {$urandom, $urandom};
      key_pool[0] = 64'hFFFF_FFFF_FFFF_FFFF;
      key_pool[1] = 64'd1;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: ownership, hidden aging, empty key, ties, no-winner frames
      send_item(64'hFFFF_FFFF_FFFF_FFFF, 1, 32'hFFFF_FFFF, 0, 0);
      send_item(64'd1, 0, 32'd0, 0, 1);
      send_item(64'd0, 1, 32'd5, 0, 0);
      send_item(64'd2, 1, 32'd100, 0, 0);
      send_item(64'd3, 1, 32'd100, 1, 2);
      csr_write(REG_GRACE, 0);
      csr_write(REG_RETENTION, 32'hFFFF);
      send_item(64'd1, 0, 32'd7, 0, 0);
      send_item(64'd1, 1, 32'd9, 0, 0);
      send_item(64'd2, 0, 32'h0001_0000, 0, 0);
      send_item(64'hFFFF_FFFF_FFFF_FFFF, 0, 32'd0, 1, 0);
      send_item(64'd0, 0, 32'd0, 1, 0);
      csr_write(REG_ACTIVE, 2);
      send_item(64'd9, 1, 32'd50, 0, 0);
      send_item(64'd10, 1, 32'd60, 0, 0);
      send_item(64'd11, 1, 32'd70, 1, 0);
      send_item(64'd9, 1, 32'd80, 0, 0);
      // shrink the slot count mid-frame
      csr_write(REG_ACTIVE, 1);
      send_item(64'd12, 1, 32'd90, 1, 0);
      csr_write(REG_ACTIVE, 0);
      send_item(64'd13, 1, 32'd1, 1, 0);
      csr_write(REG_RETENTION, 16);
      csr_write(REG_ACTIVE, 8);

      // random: frames drawn from a small key pool so owners recur
      items = 0;
      for (int p = 0; p < 6; p++) begin
         csr_write(REG_RETENTION, p == 5 ? $urandom : ret_set[p]);
         csr_write(REG_GRACE, grace_set[p]);
         csr_write(REG_ACTIVE, act_set[p]);
         for (int f = 0; f < 4; f++) begin
            int len;
            len = $urandom_range(1, 12);
            random_frame(len);
            items += len;
            if (f == 1) wait_idle();
         end
      end
      csr_write(REG_ACTIVE, 8);
      csr_write(REG_GRACE, 3);
      while (items < 160) begin
         int len;
         len = $urandom_range(1, 10);
         random_frame(len);
         items += len;
      end

      wait_idle();
      repeat (30) @(posedge clock);
      if (fail_count == 0) $display("shadow_slot_allocator_unit test passed");
      else $display("shadow_slot_allocator_unit test failed");
      $finish;
   end

   initial begin
      #5ms;
      $display("shadow_slot_allocator_unit test failed");
      $finish;
   end
endmodule
